FILE: src/cidc_pkg.sv
// Package for the identifier census: payload structs, op and kind codes, state enums.
// No dependencies.
package cidc_pkg;

   localparam logic OP_FRAME  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam int MAX_REPORTS = 32;
   localparam logic [9:0] RATE_SCALE = 10'd1000;
   localparam logic [15:0] RATE_MAX = 16'hFFFF;

   typedef struct packed {
      logic        op;
      logic [28:0] frame_id;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  slot;
      logic        is_new;
      logic        overflowed;
      logic [28:0] entry_id;
      logic [31:0] entry_hits;
      logic [15:0] entry_rate;
      logic [31:0] overflow_count;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCAN,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

FILE: src/can_id_census_with_rates.sv
// Top level of the identifier census with per-identifier hit rates.
// Depends on cidc_pkg, cidc_front and cidc_back.
//
// Usage:
//   req_ channel: drive start with req_data; a transaction is taken at an edge
//   where start is high and busy is low. op 0 logs a frame id, op 1 takes a
//   rate sample over elapsed_ms.
//   rsp_ channel: rsp_valid strobes each result for one cycle; the receiver
//   cannot stall, so results must be taken as they come. rsp_data.last marks
//   the final result of a transaction.
// Flow:
//   A two-entry queue decouples acceptance from the table engine.
//   Each slot searched takes a registered read, then a compare. A frame result
//   comes when the search reaches a match, or ends for a new or refused id. A
//   sample gives its entries one after another, each rate from the 42-step
//   bit-serial rate divider; an empty sample is answered from the idle state.
// Reset:
//   Synchronous reset empties the table (used count zero), clears the refused
//   count and the queue. Table memories are not cleared; only filled slots are read.
module can_id_census_with_rates #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cidc_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output cidc_pkg::rsp_type rsp_data
);
   import cidc_pkg::*;

   logic    q_valid, q_pop;
   req_type q_data;

   cidc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   cidc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .done     (rsp_valid),
      .rsp_data (rsp_data)
   );
endmodule

FILE: src/cidc_front.sv
// Front end: accepts a transaction and holds it in a two-entry queue for the back end.
// Depends on cidc_pkg.
module cidc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cidc_pkg::req_type req_data,
   output logic              busy,
   output logic              q_valid,
   output cidc_pkg::req_type q_data,
   input  logic              q_pop
);
   import cidc_pkg::*;

   req_type    entry_ff [2];
   req_type    entry_in [2];
   logic [1:0] count_ff, count_in;
   logic       push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = entry_ff[0];

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (q_pop && q_valid) begin
         entry_in[0] = entry_ff[1];
         count_in    = count_in - 2'd1;
      end
      if (push) begin
         entry_in[count_in[0]] = req_data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push && !(q_pop && q_valid)) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue push lost");
   assert property (@(posedge clock) disable iff (reset) !q_valid |-> !(q_pop))
      else $error("pop from empty queue");
endmodule

FILE: src/cidc_divider.sv
// Restoring divider: 42-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on cidc_pkg; saturates the quotient to 16 bits.
module cidc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [41:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   import cidc_pkg::*;

   logic [41:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [16:0] trial;

   assign trial = {rem_ff[15:0], quo_ff[41]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 6'd42;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[40:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[40:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (go) begin
         div_ff <= divisor;
      end
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign done     = run_ff && (cnt_ff == 6'd1);
   assign quotient = (quo_in[41:16] != '0) ? RATE_MAX : quo_in[15:0];
endmodule

FILE: src/cidc_back.sv
// Back end: table search, insertion, sample scan with rate division, result strobe.
// Depends on cidc_pkg and cidc_divider.
module cidc_back #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cidc_pkg::req_type q_data,
   output logic              q_pop,
   output logic              done,
   output cidc_pkg::rsp_type rsp_data
);
   import cidc_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [28:0] ids_mem   [TABLE_DEPTH];
   logic [31:0] hits_mem  [TABLE_DEPTH];
   logic [31:0] base_mem  [TABLE_DEPTH];

   state_type   state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [31:0] refused_ff, refused_in;
   logic [CW-1:0] idx_ff, idx_in;
   req_type     cur_ff, cur_in;
   rsp_type     rsp_ff, rsp_in;
   logic        done_ff, done_in;
   logic [28:0] rd_id_ff;
   logic [31:0] rd_hits_ff, rd_base_ff;
   logic        rd_ok_ff, rd_ok_in;

   logic        wr_id, wr_hits, wr_base;
   logic [IW-1:0] wr_addr;
   logic [28:0] wr_id_val;
   logic [31:0] wr_hits_val;
   logic        div_go, div_done;
   logic [15:0] div_q;
   logic [31:0] delta;
   logic [41:0] product;

   assign delta   = rd_hits_ff - rd_base_ff;
   assign product = {10'd0, delta} * {32'd0, RATE_SCALE};

   always_ff @(posedge clock) begin
      if (wr_id) begin
         ids_mem[wr_addr] <= wr_id_val;
      end
      if (wr_hits) begin
         hits_mem[wr_addr] <= wr_hits_val;
      end
      if (wr_base) begin
         base_mem[wr_addr] <= wr_hits ? 32'd0 : rd_hits_ff;
      end
      rd_id_ff   <= ids_mem[idx_in[IW-1:0]];
      rd_hits_ff <= hits_mem[idx_in[IW-1:0]];
      rd_base_ff <= base_mem[idx_in[IW-1:0]];
   end

   cidc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (product),
      .divisor  (cur_ff.elapsed_ms),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      refused_in  = refused_ff;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      rsp_in      = rsp_ff;
      done_in     = 1'b0;
      rd_ok_in    = 1'b0;
      q_pop       = 1'b0;
      wr_id       = 1'b0;
      wr_hits     = 1'b0;
      wr_base     = 1'b0;
      wr_addr     = idx_ff[IW-1:0];
      wr_id_val   = cur_ff.frame_id;
      wr_hits_val = 32'd1;
      div_go      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               if (q_data.op == OP_FRAME) begin
                  state_in = ST_SEARCH;
               end else if (q_data.elapsed_ms == 16'd0 || used_ff == '0) begin
                  rsp_in.kind = KIND_EMPTY;
                  rsp_in.overflow_count = refused_ff;
                  done_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SEARCH: begin
            // read data is registered from idx_in, so it lines up with idx_ff; rd_ok_ff marks it valid
            rd_ok_in = 1'b1;
            rsp_in.kind = KIND_FRAME;
            if (rd_ok_ff && rd_id_ff == cur_ff.frame_id && idx_ff < used_ff) begin
               wr_hits     = 1'b1;
               wr_hits_val = rd_hits_ff + 32'd1;
               rsp_in.slot = 5'(idx_ff);
               rsp_in.entry_id   = rd_id_ff;
               rsp_in.entry_hits = wr_hits_val;
               rsp_in.overflow_count = refused_ff;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (!rd_ok_ff) begin
               idx_in = idx_ff;
            end else if (idx_ff + CW'(1) < used_ff) begin
               idx_in = idx_ff + CW'(1);
               rd_ok_in = 1'b0;
            end else if (used_ff < CW'(TABLE_DEPTH)) begin
               wr_addr = used_ff[IW-1:0];
               wr_id   = 1'b1;
               wr_hits = 1'b1;
               wr_base = 1'b1;
               used_in = used_ff + CW'(1);
               rsp_in.slot = 5'(used_ff);
               rsp_in.is_new = 1'b1;
               rsp_in.entry_id = cur_ff.frame_id;
               rsp_in.entry_hits = 32'd1;
               rsp_in.overflow_count = refused_ff;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               refused_in = refused_ff + 32'd1;
               rsp_in.overflowed = 1'b1;
               rsp_in.entry_id = cur_ff.frame_id;
               rsp_in.overflow_count = refused_in;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
            if (used_ff == '0) begin
               rd_ok_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // wait for the registered slot read, marked by rd_ok_ff
            rd_ok_in = 1'b1;
            if (rd_ok_ff) begin
               div_go   = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wr_base = 1'b1;
               rsp_in.kind = KIND_ENTRY;
               rsp_in.slot = 5'(idx_ff);
               rsp_in.is_new = 1'b0;
               rsp_in.overflowed = 1'b0;
               rsp_in.entry_id = rd_id_ff;
               rsp_in.entry_hits = rd_hits_ff;
               rsp_in.entry_rate = div_q;
               rsp_in.overflow_count = refused_ff;
               rsp_in.last = (idx_ff + CW'(1) == used_ff) ||
                             (32'(idx_ff) + 32'd1 == 32'(MAX_REPORTS));
               done_in = (32'(idx_ff) < 32'(MAX_REPORTS));
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (idx_ff + CW'(1) < used_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the no-match step in search must also handle an empty table
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         refused_ff <= '0;
         idx_ff     <= '0;
         done_ff    <= 1'b0;
         rd_ok_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         refused_ff <= refused_in;
         idx_ff     <= idx_in;
         done_ff    <= done_in;
         rd_ok_ff   <= rd_ok_in;
      end
   end

   assign done     = done_ff;
   assign rsp_data = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) used_ff <= CW'(TABLE_DEPTH))
      else $error("used count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("pop while working");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");
endmodule

FILE: tb/tb_can_id_census_with_rates.sv
// Testbench for the identifier census: directed and random frame/sample transactions,
// checked against a built-in predictor. Depends on cidc_pkg and can_id_census_with_rates.
module tb_can_id_census_with_rates;
   timeunit 1ns;
   timeprecision 1ps;
   import cidc_pkg::*;

   localparam int SLOTS = 32;
   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   can_id_census_with_rates #(.TABLE_DEPTH(SLOTS)) uut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [28:0] census_ids [SLOTS];
   logic [31:0] census_hits [SLOTS];
   logic [31:0] census_base [SLOTS];
   int          census_used;
   logic [31:0] census_refused;

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      rsp_seen = 0;
   int      frames_sent = 0;
   int      samples_sent = 0;
   int      cycles = 0;

   function automatic rsp_type make_rsp(logic [1:0] kind, int slot, logic is_new,
                                        logic ovf, logic [28:0] id, logic [31:0] hits,
                                        logic [15:0] rate, logic last);
      rsp_type r;
      r.kind = kind; r.slot = slot[4:0]; r.is_new = is_new; r.overflowed = ovf;
      r.entry_id = id; r.entry_hits = hits; r.entry_rate = rate;
      r.overflow_count = census_refused; r.last = last;
      return r;
   endfunction

   task automatic predict_census(req_type t);
      bit          found;
      logic [31:0] delta;
      logic [63:0] rate;
      found = 0;
      if (t.op == OP_FRAME) begin
         for (int i = 0; i < census_used && !found; i++)
            if (census_ids[i] == t.frame_id) begin
               census_hits[i] = census_hits[i] + 32'd1;
               expected_rsps.push_back(make_rsp(KIND_FRAME, i, 1'b0, 1'b0, t.frame_id,
                                                census_hits[i], 16'd0, 1'b1));
               found = 1;
            end
         if (!found) begin
            if (census_used < SLOTS) begin
               census_ids[census_used] = t.frame_id;
               census_hits[census_used] = 32'd1;
               census_base[census_used] = 32'd0;
               expected_rsps.push_back(make_rsp(KIND_FRAME, census_used, 1'b1, 1'b0,
                                                t.frame_id, 32'd1, 16'd0, 1'b1));
               census_used++;
            end else begin
               census_refused = census_refused + 32'd1;
               expected_rsps.push_back(make_rsp(KIND_FRAME, 0, 1'b0, 1'b1, t.frame_id,
                                                32'd0, 16'd0, 1'b1));
            end
         end
      end else if (t.elapsed_ms == 16'd0 || census_used == 0) begin
         expected_rsps.push_back(make_rsp(KIND_EMPTY, 0, 1'b0, 1'b0, 29'd0, 32'd0,
                                          16'd0, 1'b1));
      end else begin
         for (int i = 0; i < census_used; i++) begin
            delta = census_hits[i] - census_base[i];
            rate = (64'(delta) * 64'd1000) / 64'(t.elapsed_ms);
            if (rate > 64'hFFFF) rate = 64'hFFFF;
            expected_rsps.push_back(make_rsp(KIND_ENTRY, i, 1'b0, 1'b0, census_ids[i],
                                             census_hits[i], rate[15:0],
                                             i + 1 == census_used));
            census_base[i] = census_hits[i];
         end
      end
   endtask

   // send one transaction after a random gap; start stays high across back-to-back sends
   task automatic send_item(logic op, logic [28:0] id, logic [15:0] ms);
      int gap;
      req_type t;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      t.op = op; t.frame_id = id; t.elapsed_ms = ms;
      start <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_census(t);
      if (op == OP_FRAME) frames_sent++; else samples_sent++;
   endtask

   task automatic drain_rsps();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   task automatic test_directed_edges();
      send_item(OP_SAMPLE, 29'd0, 16'd100);        // empty table
      send_item(OP_FRAME, 29'h0, 16'd0);
      send_item(OP_FRAME, 29'h1FFFFFFF, 16'hFFFF);
      send_item(OP_FRAME, 29'h0, 16'd0);           // matched
      send_item(OP_SAMPLE, 29'd0, 16'd0);          // zero elapsed
      send_item(OP_SAMPLE, 29'd0, 16'd1);          // smallest nonzero elapsed
      send_item(OP_SAMPLE, 29'd0, 16'hFFFF);       // zero delta
      send_item(OP_FRAME, 29'h1FFFFFFF, 16'd0);
      send_item(OP_SAMPLE, 29'd0, 16'd1000);
      drain_rsps();
   endtask

   task automatic test_fill_and_overflow();
      for (int i = 0; i < SLOTS + 4; i++) send_item(OP_FRAME, 29'h100 + 29'(i), 16'd0);
      send_item(OP_FRAME, 29'h1FFFFFFF, 16'd0);
      send_item(OP_FRAME, 29'h1ABCDE, 16'd0);
      send_item(OP_SAMPLE, 29'd0, 16'd7);
      drain_rsps();
   endtask

   // random frames and occasional samples; the table stays full after the fill test,
   // so mix repeats of stored ids with new ones
   task automatic test_random_traffic(int n);
      logic [28:0] id;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(OP_SAMPLE, 29'($urandom), $urandom_range(0, 3) == 0 ?
                      16'($urandom_range(0, 3)) : 16'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: id = 29'($urandom);
               1: id = 29'h100 + 29'($urandom_range(0, SLOTS - 1));
               2: id = 29'h1FFFFFFF;
               default: id = 29'h100 + 29'($urandom_range(0, 3));
            endcase
            send_item(OP_FRAME, id, 16'($urandom));
         end
         if (k == n / 2) drain_rsps();           // hold off until all results are in
      end
      send_item(OP_SAMPLE, 29'd0, 16'($urandom_range(1, 65535)));
      drain_rsps();
   endtask

   initial begin
      census_used = 0;
      census_refused = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_fill_and_overflow();
      test_random_traffic(400);
      $display("Sent %0d frames and %0d samples, checked %0d results; %0d refused ids",
               frames_sent, samples_sent, rsp_seen, census_refused);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_rsps.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

FILE: files.f
src/cidc_pkg.sv
src/cidc_front.sv
src/cidc_divider.sv
src/cidc_back.sv
src/can_id_census_with_rates.sv
tb/tb_can_id_census_with_rates.sv
